// ----- rtl/todt_pkg.sv -----
// Shared widths, codes, reset values and types of the on/off delay timer.
package todt_pkg;

   localparam int LEVEL_WIDTH = 16;
   localparam int COUNT_WIDTH = 20;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = COUNT_WIDTH;

   localparam logic [LEVEL_WIDTH-1:0] THRESHOLD_RESET = 16'h8000;
   localparam logic [COUNT_WIDTH-1:0] ON_DELAY_RESET = '0;
   localparam logic [COUNT_WIDTH-1:0] OFF_DELAY_RESET = '0;

   // Register map of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_ON_DELAY  = 2'd1,
      CSR_OFF_DELAY = 2'd2
   } csr_index_type;

   // Item kinds on the request channel
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } command_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] threshold;
      logic [COUNT_WIDTH-1:0] on_delay;
      logic [COUNT_WIDTH-1:0] off_delay;
   } cfg_type;

endpackage

// ----- rtl/todt_if.sv -----
// Valid/ready channel interfaces for requests and responses of the timer.
interface todt_req_if;
   import todt_pkg::*;

   logic                   valid;
   logic                   ready;
   command_type            command;
   logic [LEVEL_WIDTH-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

interface todt_rsp_if;
   logic valid;
   logic ready;
   logic output_level;

   modport source (output valid, output output_level, input ready);
   modport sink   (input valid, input output_level, output ready);
endinterface

// ----- rtl/todt_csr.sv -----
// Configuration registers of the timer: threshold, on-delay and off-delay.
module todt_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [todt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [todt_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output todt_pkg::cfg_type                      cfg
);
   import todt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write, truncating data to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: cfg_in.threshold = csr_write_data[LEVEL_WIDTH-1:0];
            CSR_ON_DELAY:  cfg_in.on_delay  = csr_write_data[COUNT_WIDTH-1:0];
            CSR_OFF_DELAY: cfg_in.off_delay = csr_write_data[COUNT_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.on_delay  <= ON_DELAY_RESET;
         cfg_ff.off_delay <= OFF_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/todt_step.sv -----
// Timer state and its update for one sample or tick.
module todt_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  todt_pkg::command_type             command,
   input  logic [todt_pkg::LEVEL_WIDTH-1:0]  sample,
   input  todt_pkg::cfg_type                 cfg,
   output logic                              output_level_next
);
   import todt_pkg::*;

   logic                   last_above_ff, last_above_in;
   logic                   on_running_ff, on_running_in;
   logic [COUNT_WIDTH-1:0] on_count_ff, on_count_in;
   logic                   off_running_ff, off_running_in;
   logic [COUNT_WIDTH-1:0] off_count_ff, off_count_in;
   logic                   output_active_ff, output_active_in;
   logic                   above;
   logic                   on_expire;
   logic                   off_expire;

   assign above      = (sample >= cfg.threshold);
   assign on_expire  = (on_count_ff <= COUNT_WIDTH'(1));
   assign off_expire = (off_count_ff <= COUNT_WIDTH'(1));

   // Work out the state after the current item
   always_comb begin
      last_above_in    = last_above_ff;
      on_running_in    = on_running_ff;
      on_count_in      = on_count_ff;
      off_running_in   = off_running_ff;
      off_count_in     = off_count_ff;
      output_active_in = output_active_ff;
      if (command == CMD_TICK) begin
         // Count down the on-delay first, then the off-delay
         if (on_running_ff) begin
            if (on_expire) begin
               on_running_in    = 1'b0;
               on_count_in      = '0;
               output_active_in = 1'b1;
            end else begin
               on_count_in = on_count_ff - COUNT_WIDTH'(1);
            end
         end
         if (off_running_ff) begin
            if (off_expire) begin
               off_running_in   = 1'b0;
               off_count_in     = '0;
               output_active_in = 1'b0;
            end else begin
               off_count_in = off_count_ff - COUNT_WIDTH'(1);
            end
         end
      end else begin
         // Rising crossing drops the off-delay, falling one the on-delay
         if (above && !last_above_ff) begin
            off_running_in = 1'b0;
            if (!output_active_ff && !on_running_ff) begin
               on_running_in = 1'b1;
               on_count_in   = cfg.on_delay;
            end
         end else if (!above && last_above_ff) begin
            on_running_in = 1'b0;
            if (output_active_ff && !off_running_ff) begin
               off_running_in = 1'b1;
               off_count_in   = cfg.off_delay;
            end
         end
         last_above_in = above;
      end
   end

   // Commit the state when the item moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_above_ff    <= 1'b0;
         on_running_ff    <= 1'b0;
         on_count_ff      <= '0;
         off_running_ff   <= 1'b0;
         off_count_ff     <= '0;
         output_active_ff <= 1'b0;
      end else if (advance) begin
         last_above_ff    <= last_above_in;
         on_running_ff    <= on_running_in;
         on_count_ff      <= on_count_in;
         off_running_ff   <= off_running_in;
         off_count_ff     <= off_count_in;
         output_active_ff <= output_active_in;
      end
   end

   assign output_level_next = output_active_in;

   // The two delays never run together
   assert property (@(posedge clock) disable iff (reset)
      !(on_running_ff && off_running_ff))
      else $error("on-delay and off-delay running together");

   // A running on-delay implies the output is off, a running off-delay that it is on
   assert property (@(posedge clock) disable iff (reset)
      (!on_running_ff || !output_active_ff) && (!off_running_ff || output_active_ff))
      else $error("delay running against the output level");

   // An expiring on-delay turns the output on
   assert property (@(posedge clock) disable iff (reset)
      (advance && command == CMD_TICK && on_running_ff && on_expire)
      |=> (output_active_ff && !on_running_ff))
      else $error("on-delay expired without turning the output on");

endmodule

// ----- rtl/threshold_on_off_delay_timer_core.sv -----
// Top level of the threshold on/off delay timer: input and response registers.
// A request is held in the input register and its response in the response register.
// Throughput: one request per cycle unless the response channel stalls; the state update
// is three compares and two 20-bit decrements between the input and response registers.
// Reset: synchronous, active high; clears both pipeline stages and the timer
// state, and loads threshold 32768 with both delays at zero.
module threshold_on_off_delay_timer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   todt_req_if.sink                             req_chan,
   todt_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [todt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [todt_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import todt_pkg::*;

   cfg_type                cfg;
   logic                   s1_valid_ff, s1_valid_in;
   command_type            s1_command_ff;
   logic [LEVEL_WIDTH-1:0] s1_sample_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_level_ff;
   logic                   level_next;
   logic                   req_transfer;
   logic                   s1_advance;

   todt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   todt_step u_step (
      .clock             (clock),
      .reset             (reset),
      .advance           (s1_advance),
      .command           (s1_command_ff),
      .sample            (s1_sample_ff),
      .cfg               (cfg),
      .output_level_next (level_next)
   );

   // Advance the input stage whenever the response register is free or drains
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_transfer   = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_transfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_command_ff <= req_chan.command;
         s1_sample_ff  <= req_chan.sample;
      end
      if (s1_advance) begin
         rsp_level_ff <= level_next;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.output_level = rsp_level_ff;

   // An item leaving the input stage always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced item lost before the response register");

   // A stalled input stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("stalled input stage dropped its item");

   // The input stage only stalls behind a full, blocked response register
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("input stage stalled without back-pressure");

endmodule
